// File: design/glos_pkg.sv
// Shared constants, types and helpers of the grid line-of-sight checker.
package glos_pkg;

    localparam int MAP_WIDTH  = 256;
    localparam int MAP_HEIGHT = 256;

    localparam int COL_AW  = $clog2(MAP_WIDTH);
    localparam int ROW_AW  = $clog2(MAP_HEIGHT);
    localparam int FIELD_W = 8;
    localparam int DIM_AW  = (COL_AW > ROW_AW) ? COL_AW : ROW_AW;
    // Signed coordinates with room for one cell beyond either border.
    localparam int CRD_W   = ((DIM_AW > FIELD_W) ? DIM_AW : FIELD_W) + 2;
    localparam int ERR_W   = CRD_W + 2;

    // Input beat layout of s_tdata, lowest bit first.
    localparam int WR_X_LSB   = 0;
    localparam int WR_Y_LSB   = 8;
    localparam int WR_BLK_BIT = 16;
    localparam int FROM_X_LSB = 17;
    localparam int FROM_Y_LSB = 25;
    localparam int TO_X_LSB   = 33;
    localparam int TO_Y_LSB   = 41;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 8;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef logic signed [CRD_W-1:0] crd_t;
    typedef logic signed [ERR_W-1:0] err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Which row of the 3x3 window is being read.
    typedef logic [1:0] phase_t;
    localparam phase_t PH_ABOVE  = 2'd0;
    localparam phase_t PH_CENTER = 2'd1;
    localparam phase_t PH_BELOW  = 2'd2;

    typedef struct packed {
        logic load;
        logic advance;
    } step_ctrl_t;

    typedef struct packed {
        crd_t cx;
        crd_t cy;
        logic at_end;
    } step_stat_t;

    function automatic crd_t to_crd(input logic [FIELD_W-1:0] v);
        return crd_t'({{(CRD_W-FIELD_W){1'b0}}, v});
    endfunction

    function automatic logic in_map_x(input crd_t x);
        return (x >= crd_t'(0)) && (x < crd_t'(MAP_WIDTH));
    endfunction

    function automatic logic in_map_y(input crd_t y);
        return (y >= crd_t'(0)) && (y < crd_t'(MAP_HEIGHT));
    endfunction

endpackage

// File: design/glos_map.sv
// Row-organized occupancy map with a clearing pass after reset.
module glos_map import glos_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [ROW_AW-1:0] wr_row,
    input  logic [COL_AW-1:0] wr_col,
    input  logic              wr_val,
    input  logic [ROW_AW-1:0] rd_row,
    output logic [MAP_WIDTH-1:0] rd_data,
    output logic              busy
);

    logic [MAP_WIDTH-1:0] mem [MAP_HEIGHT];
    logic [MAP_WIDTH-1:0] rd_data_reg;
    logic [ROW_AW-1:0]    clr_row_reg, clr_row_next;
    logic                 clearing_reg, clearing_next;

    always_comb begin
        clr_row_next  = clr_row_reg;
        clearing_next = clearing_reg;
        if (clearing_reg) begin
            clr_row_next = clr_row_reg + ROW_AW'(1);
            if (clr_row_reg == ROW_AW'(MAP_HEIGHT - 1)) begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_row_reg  <= '0;
        end else begin
            clearing_reg <= clearing_next;
            clr_row_reg  <= clr_row_next;
        end
    end

    // One whole row is cleared per cycle; otherwise single-bit writes.
    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_row_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_row][wr_col] <= wr_val;
        end
        rd_data_reg <= mem[rd_row];
    end

    assign rd_data = rd_data_reg;
    assign busy    = clearing_reg;

endmodule

// File: design/glos_stepper.sv
// Bresenham line stepper: holds the current cell and the error term.
module glos_stepper import glos_pkg::*; (
    input  logic       aclk,
    input  step_ctrl_t ctrl,
    input  crd_t       from_x,
    input  crd_t       from_y,
    input  crd_t       to_x,
    input  crd_t       to_y,
    output step_stat_t stat
);

    crd_t x_reg, y_reg, x1_reg, y1_reg;
    crd_t x_next, y_next, x1_next, y1_next;
    err_t dx_reg, dy_reg, err_reg;
    err_t dx_next, dy_next, err_next;
    logic sx_reg, sy_reg, sx_next, sy_next;
    err_t e2;
    logic move_x, move_y;

    always_comb begin
        x_next   = x_reg;
        y_next   = y_reg;
        x1_next  = x1_reg;
        y1_next  = y1_reg;
        dx_next  = dx_reg;
        dy_next  = dy_reg;
        err_next = err_reg;
        sx_next  = sx_reg;
        sy_next  = sy_reg;
        e2       = err_reg <<< 1;
        move_x   = e2 > -dy_reg;
        move_y   = e2 < dx_reg;
        if (ctrl.load) begin
            x_next  = from_x;
            y_next  = from_y;
            x1_next = to_x;
            y1_next = to_y;
            dx_next = (to_x > from_x) ? err_t'(to_x) - err_t'(from_x)
                                      : err_t'(from_x) - err_t'(to_x);
            dy_next = (to_y > from_y) ? err_t'(to_y) - err_t'(from_y)
                                      : err_t'(from_y) - err_t'(to_y);
            sx_next = from_x < to_x;
            sy_next = from_y < to_y;
            err_next = dx_next - dy_next;
        end else if (ctrl.advance) begin
            err_next = err_reg - (move_x ? dy_reg : err_t'(0))
                               + (move_y ? dx_reg : err_t'(0));
            if (move_x) begin
                x_next = sx_reg ? x_reg + crd_t'(1) : x_reg - crd_t'(1);
            end
            if (move_y) begin
                y_next = sy_reg ? y_reg + crd_t'(1) : y_reg - crd_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        x1_reg  <= x1_next;
        y1_reg  <= y1_next;
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        err_reg <= err_next;
        sx_reg  <= sx_next;
        sy_reg  <= sy_next;
    end

    assign stat.cx     = x_reg;
    assign stat.cy     = y_reg;
    assign stat.at_end = (x_reg == x1_reg) && (y_reg == y1_reg);

endmodule

// File: design/grid_line_of_sight_check_core.sv
// Top level of the grid line-of-sight checker: control sequencer and window check.
// A map write beat completes in the cycle it is accepted and gives no result.
// A query walks the line cells from acceptance to the result beat, with three
// map row reads per cell (one row per cycle, through the single read port),
// and stops early at the first blocked row; one query at a time.
// After reset the map clearing pass holds s_tready low until every row is cleared.
module grid_line_of_sight_check_core import glos_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Fields from bit 0 up: write_x, write_y, write_blocked, from_x, from_y,
    // to_x, to_y, then zero fill.
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Fields from bit 0 up: mode.
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Fields from bit 0 up: line_clear, then zero fill.
    output logic [M_TDATA_W-1:0] m_tdata
);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    // Check stage: what was asked of the map in the previous cycle.
    logic chk_valid_reg, chk_valid_next;
    crd_t chk_cx_reg;
    logic chk_row_ok_reg;
    logic chk_blocked;

    logic result_reg, result_next;
    logic m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic load_out;
    logic issue;

    step_ctrl_t step_ctrl;
    step_stat_t step_stat;

    logic [MAP_WIDTH-1:0] row_data;
    logic                 map_busy;
    logic                 map_wr_en;
    crd_t                 wr_x, wr_y;
    crd_t                 row_crd;
    logic                 row_ok;
    logic                 s_beat;

    // Input is taken only while idle and once the clearing pass is over.
    assign s_tready = (state_reg == ST_IDLE) && !map_busy;
    assign s_beat   = s_tvalid && s_tready;
    assign wr_x     = to_crd(s_tdata[WR_X_LSB +: FIELD_W]);
    assign wr_y     = to_crd(s_tdata[WR_Y_LSB +: FIELD_W]);

    // Writes outside the map are dropped.
    assign map_wr_en = s_beat && (s_tuser == MODE_WRITE) && in_map_x(wr_x) && in_map_y(wr_y);

    // Row of the window addressed this cycle: the phase walks above, center, below.
    assign row_crd = step_stat.cy + crd_t'(phase_reg) - crd_t'(1);
    assign row_ok  = in_map_y(row_crd);

    glos_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (map_wr_en),
        .wr_row  (wr_y[ROW_AW-1:0]),
        .wr_col  (wr_x[COL_AW-1:0]),
        .wr_val  (s_tdata[WR_BLK_BIT]),
        .rd_row  (row_crd[ROW_AW-1:0]),
        .rd_data (row_data),
        .busy    (map_busy)
    );

    glos_stepper u_stepper (
        .aclk   (aclk),
        .ctrl   (step_ctrl),
        .from_x (to_crd(s_tdata[FROM_X_LSB +: FIELD_W])),
        .from_y (to_crd(s_tdata[FROM_Y_LSB +: FIELD_W])),
        .to_x   (to_crd(s_tdata[TO_X_LSB +: FIELD_W])),
        .to_y   (to_crd(s_tdata[TO_Y_LSB +: FIELD_W])),
        .stat   (step_stat)
    );

    // A row is blocked if it lies off the map, or if any of the three columns
    // around the center is off the map or marked occupied.
    always_comb begin
        crd_t col;
        chk_blocked = !chk_row_ok_reg;
        for (int k = 0; k < 3; k++) begin
            col = chk_cx_reg + crd_t'(k) - crd_t'(1);
            if (!in_map_x(col)) begin
                chk_blocked = 1'b1;
            end else if (row_data[col[COL_AW-1:0]]) begin
                chk_blocked = 1'b1;
            end
        end
    end

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        result_next = result_reg;
        step_ctrl   = '0;
        issue       = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_beat && (s_tuser == MODE_QUERY)) begin
                    step_ctrl.load = 1'b1;
                    phase_next     = PH_ABOVE;
                    state_next     = ST_WALK;
                end
            end
            ST_WALK: begin
                issue = 1'b1;
                if (chk_valid_reg && chk_blocked) begin
                    result_next = 1'b0;
                    state_next  = ST_DONE;
                end else if (phase_reg == PH_BELOW) begin
                    phase_next = PH_ABOVE;
                    if (step_stat.at_end) begin
                        state_next = ST_DRAIN;
                    end else begin
                        step_ctrl.advance = 1'b1;
                    end
                end else begin
                    phase_next = phase_reg + phase_t'(1);
                end
            end
            ST_DRAIN: begin
                // The bottom row of the last cell is the only one still open.
                if (chk_valid_reg) begin
                    result_next = !chk_blocked;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        chk_valid_next = issue && (state_next != ST_DONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_ABOVE;
            chk_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            chk_valid_reg <= chk_valid_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        chk_cx_reg     <= step_stat.cx;
        chk_row_ok_reg <= row_ok;
        result_reg     <= result_next;
        if (load_out) begin
            m_data_reg <= M_TDATA_W'(result_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_chk_only_walking: assert property (@(posedge aclk) disable iff (!aresetn)
        chk_valid_reg |-> (state_reg == ST_WALK || state_reg == ST_DRAIN))
        else $error("check stage active outside a line walk");

    a_drain_has_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> (chk_valid_reg && step_stat.at_end))
        else $error("drain entered without a pending last-row check");

    a_no_query_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        map_busy |-> (state_reg == ST_IDLE && !s_tready))
        else $error("map accessed during clearing pass");

    a_done_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !m_tvalid_reg) |=> (m_tvalid_reg && state_reg == ST_IDLE))
        else $error("finished query did not reach the output register");
`endif

endmodule
